### rtl/assert_macros.svh
// Assertion macros for the checker module of the page walker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted (active low).
`define FWPW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define FWPW_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fwpw_pkg.sv
// Shared types and constants for the four-level page walker.
// No dependencies; used by the controller, datapath, top level and checker.
`default_nettype none

package fwpw_pkg;

    // Operation codes of an input transaction
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_ROOT_BASE = 1'b0;
    localparam t_cfg_index CFG_LARGE_1G  = 1'b1;
    localparam int         CFG_DATA_W    = 52;

    // Table geometry: 512 entries of 8 bytes per table
    localparam int IDX_W = 9;

    // Entry bit positions
    localparam int PTE_PRESENT_BIT = 0;
    localparam int PTE_WRITE_BIT   = 1;
    localparam int PTE_USER_BIT    = 2;
    localparam int PTE_SIZE_BIT    = 7;
    localparam int PTE_NOEXEC_BIT  = 63;

    // Walk level, 3 is the top-level table
    typedef logic [1:0] t_level;
    localparam t_level LVL_L0 = 2'd0;
    localparam t_level LVL_L1 = 2'd1;
    localparam t_level LVL_L2 = 2'd2;
    localparam t_level LVL_L3 = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic   clear_en;
        logic   wr_en;
        logic   walk_start;
        logic   walk_step;
        logic   finish;
        t_level level;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic present;
        logic leaf;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/four_level_page_walk.sv
// Four-level page walker over a local table store; top level.
// Depends on fwpw_pkg, fwpw_ctrl and fwpw_datapath.
//
// A transaction is taken when start is high and busy is low. A write transaction
// stores one 64-bit table word and gives no result. A translate transaction reads
// one table entry per cycle through the store's registered read port, up to four in
// a chain, and its result appears on o_result_valid for exactly one cycle, registered
// after the last entry is read; busy falls in that strobe cycle, so the next
// transaction may be taken there. The receiver cannot stall and must take each
// result in its strobe cycle. After reset the store is swept to zero, one word a
// cycle, over all STORE_WORDS words with busy high; configuration writes are taken
// at any time. STORE_WORDS must be a power of two.
`default_nettype none

module four_level_page_walk #(
    parameter int STORE_WORDS = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_cfg_we,
    input  wire fwpw_pkg::t_cfg_index             i_cfg_index,
    input  wire logic [fwpw_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                             i_operation,
    input  wire logic [11:0]                      i_word_index,
    input  wire logic [63:0]                      i_word_value,
    input  wire logic [47:0]                      i_virtual_address,
    output logic                                  o_result_valid,
    output logic                                  o_mapped,
    output logic [51:0]                           o_physical_address,
    output logic                                  o_user_ok,
    output logic                                  o_write_ok,
    output logic                                  o_exec_ok
);

    fwpw_pkg::t_dp_cmd    dp_cmd;
    fwpw_pkg::t_dp_status dp_status;

    // Sequence the clearing pass and the walk
    fwpw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_busy      (busy)
    );

    // Store, walk registers and result
    fwpw_datapath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_status           (dp_status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_word_index       (i_word_index),
        .i_word_value       (i_word_value),
        .i_virtual_address  (i_virtual_address),
        .o_result_valid     (o_result_valid),
        .o_mapped           (o_mapped),
        .o_physical_address (o_physical_address),
        .o_user_ok          (o_user_ok),
        .o_write_ok         (o_write_ok),
        .o_exec_ok          (o_exec_ok)
    );

endmodule

`default_nettype wire

### rtl/fwpw_datapath.sv
// Datapath of the page walker: table store, configuration, walk registers, result.
// Depends on fwpw_pkg; driven by fwpw_ctrl through t_dp_cmd.
`default_nettype none

module fwpw_datapath #(
    parameter int STORE_WORDS = 4096
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fwpw_pkg::t_dp_cmd           i_cmd,
    output fwpw_pkg::t_dp_status             o_status,
    input  wire logic                        i_cfg_we,
    input  wire fwpw_pkg::t_cfg_index        i_cfg_index,
    input  wire logic [fwpw_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [11:0]                 i_word_index,
    input  wire logic [63:0]                 i_word_value,
    input  wire logic [47:0]                 i_virtual_address,
    output logic                             o_result_valid,
    output logic                             o_mapped,
    output logic [51:0]                      o_physical_address,
    output logic                             o_user_ok,
    output logic                             o_write_ok,
    output logic                             o_exec_ok
);

    // The user must keep STORE_WORDS a power of two (not checked here), so word addresses wrap by truncation
    localparam int AW = $clog2(STORE_WORDS);
    localparam int IW = (AW > 12) ? AW : 12;

    logic [63:0]   r_mem [STORE_WORDS];
    logic [63:0]   r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic [51:0]   r_root_base;
    logic          r_en_1g;
    logic [47:0]   r_va;
    logic          r_user;
    logic          r_wr;
    logic          r_ex;

    logic [IW-1:0]         word_index_wide;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         root_addr;
    logic [AW-1:0]         step_addr;
    logic [AW-1:0]         rd_addr;
    logic [fwpw_pkg::IDX_W-1:0] next_idx;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [63:0]           mem_wdata;
    logic                  e_present;
    logic                  e_size;
    logic [51:0]           leaf_pa;
    logic                  leaf;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_base <= '0;
            r_en_1g     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fwpw_pkg::CFG_ROOT_BASE: r_root_base <= i_cfg_wdata;
                fwpw_pkg::CFG_LARGE_1G:  r_en_1g     <= i_cfg_wdata[0];
                default:                 r_en_1g     <= r_en_1g;
            endcase
        end
    end

    // Sweep the store once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Wrap the write index into the store
    assign word_index_wide = IW'(i_word_index);
    assign wr_addr         = word_index_wide[AW-1:0];

    // Top-level entry address from the root and the incoming address
    assign root_addr = AW'({r_root_base[51:12], {fwpw_pkg::IDX_W{1'b0}}})
                     + AW'(i_virtual_address[47:39]);

    // Index into the next table down
    always_comb begin
        unique case (i_cmd.level)
            fwpw_pkg::LVL_L3: next_idx = r_va[38:30];
            fwpw_pkg::LVL_L2: next_idx = r_va[29:21];
            fwpw_pkg::LVL_L1: next_idx = r_va[20:12];
            fwpw_pkg::LVL_L0: next_idx = r_va[20:12];
            default:          next_idx = r_va[20:12];
        endcase
    end

    assign step_addr = AW'({r_rdata[51:12], {fwpw_pkg::IDX_W{1'b0}}}) + AW'(next_idx);
    assign rd_addr   = i_cmd.walk_start ? root_addr : step_addr;

    // Select the write source: clearing pass or a write transaction
    assign mem_we    = i_cmd.clear_en | i_cmd.wr_en;
    assign mem_waddr = i_cmd.clear_en ? r_clr_addr : wr_addr;
    assign mem_wdata = i_cmd.clear_en ? 64'd0 : i_word_value;

    // Table store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Decode the entry just read
    assign e_present = r_rdata[fwpw_pkg::PTE_PRESENT_BIT];
    assign e_size    = r_rdata[fwpw_pkg::PTE_SIZE_BIT];

    always_comb begin
        unique case (i_cmd.level)
            fwpw_pkg::LVL_L3: begin
                leaf    = 1'b0;
                leaf_pa = {r_rdata[51:12], r_va[11:0]};
            end
            fwpw_pkg::LVL_L2: begin
                leaf    = e_size & r_en_1g;
                leaf_pa = {r_rdata[51:30], r_va[29:0]};
            end
            fwpw_pkg::LVL_L1: begin
                leaf    = e_size;
                leaf_pa = {r_rdata[51:21], r_va[20:0]};
            end
            fwpw_pkg::LVL_L0: begin
                leaf    = 1'b1;
                leaf_pa = {r_rdata[51:12], r_va[11:0]};
            end
            default: begin
                leaf    = 1'b0;
                leaf_pa = '0;
            end
        endcase
    end

    assign o_status.clear_done = (r_clr_addr == AW'(STORE_WORDS - 1));
    assign o_status.present    = e_present;
    assign o_status.leaf       = leaf;

    // Hold the address and accumulate rights over the levels
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_va   <= i_virtual_address;
            r_user <= 1'b1;
            r_wr   <= 1'b1;
            r_ex   <= 1'b1;
        end else if (i_cmd.walk_step) begin
            r_user <= r_user & r_rdata[fwpw_pkg::PTE_USER_BIT];
            r_wr   <= r_wr & r_rdata[fwpw_pkg::PTE_WRITE_BIT];
            r_ex   <= r_ex & ~r_rdata[fwpw_pkg::PTE_NOEXEC_BIT];
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.finish;
        end
    end

    // Result payload; a missing level gives all zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (e_present) begin
                o_mapped           <= 1'b1;
                o_physical_address <= leaf_pa;
                o_user_ok          <= r_user & r_rdata[fwpw_pkg::PTE_USER_BIT];
                o_write_ok         <= r_wr & r_rdata[fwpw_pkg::PTE_WRITE_BIT];
                o_exec_ok          <= r_ex & ~r_rdata[fwpw_pkg::PTE_NOEXEC_BIT];
            end else begin
                o_mapped           <= 1'b0;
                o_physical_address <= '0;
                o_user_ok          <= 1'b0;
                o_write_ok         <= 1'b0;
                o_exec_ok          <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/fwpw_ctrl.sv
// Controller of the page walker: clearing pass, acceptance and level sequencing.
// Depends on fwpw_pkg; drives fwpw_datapath through t_dp_cmd.
`default_nettype none

module fwpw_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_operation,
    input  wire fwpw_pkg::t_dp_status i_status,
    output fwpw_pkg::t_dp_cmd         o_cmd,
    output logic                      o_busy
);

    fwpw_pkg::t_state r_state;
    fwpw_pkg::t_state n_state;
    fwpw_pkg::t_level r_level;
    fwpw_pkg::t_level n_level;
    logic             walk_end;

    assign walk_end = ~i_status.present | i_status.leaf;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fwpw_pkg::ST_CLEAR: begin
                if (i_status.clear_done) begin
                    n_state = fwpw_pkg::ST_IDLE;
                end
            end
            fwpw_pkg::ST_IDLE: begin
                if (i_start && i_operation == fwpw_pkg::OP_TRANSLATE) begin
                    n_state = fwpw_pkg::ST_WALK;
                end
            end
            fwpw_pkg::ST_WALK: begin
                if (walk_end) begin
                    n_state = fwpw_pkg::ST_IDLE;
                end
            end
            default: n_state = fwpw_pkg::ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.level = r_level;
        o_busy      = 1'b1;
        n_level     = r_level;
        unique case (r_state)
            fwpw_pkg::ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            fwpw_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_operation == fwpw_pkg::OP_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        n_level          = fwpw_pkg::LVL_L3;
                    end
                end
            end
            fwpw_pkg::ST_WALK: begin
                if (walk_end) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_level         = r_level - 2'd1;
                end
            end
            default: o_busy = 1'b1;
        endcase
    end

    // State and level registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwpw_pkg::ST_CLEAR;
            r_level <= fwpw_pkg::LVL_L3;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

endmodule

`default_nettype wire

### rtl/fwpw_checker.sv
// Port-level checks of the page walker, bound to four_level_page_walk.
// Depends on assert_macros.svh, fwpw_pkg and the top level's ports.
`default_nettype none
`include "assert_macros.svh"

module fwpw_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_operation,
    input wire logic o_result_valid
);

    logic acc_write;
    logic acc_translate;

    assign acc_write     = start & ~busy & (i_operation == fwpw_pkg::OP_WRITE);
    assign acc_translate = start & ~busy & (i_operation == fwpw_pkg::OP_TRANSLATE);

    // Reset starts the clearing pass
    `FWPW_ASSERT_NR(a_reset_busy, i_clk, !i_rst_n |=> busy, "busy low after reset")

    // A write transaction leaves busy low in the following cycle
    `FWPW_ASSERT(a_write_one_cycle, i_clk, i_rst_n, acc_write |=> !busy, "write held busy")

    // A translate transaction occupies the walker and yields no immediate result
    `FWPW_ASSERT(a_translate_busy, i_clk, i_rst_n, acc_translate |=> busy && !o_result_valid,
        "translate not walking")

    // A result only ends a walk
    `FWPW_ASSERT(a_result_after_walk, i_clk, i_rst_n, o_result_valid |-> $past(busy) && !busy,
        "result strobe outside a walk end")

endmodule

bind four_level_page_walk fwpw_checker u_fwpw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_result_valid (o_result_valid)
);

`default_nettype wire
